// ----- src/sla_pkg.sv -----
// package for sequence_local_alignment: constants, codes and beat types
// no dependencies
package sla_pkg;
  localparam int MAX_LEN = 32;
  localparam int SYMBOL_BITS = 8;
  localparam int SYM_W = SYMBOL_BITS;
  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int DIM = MAX_LEN + 1;
  localparam int DIM_W = $clog2(DIM);
  localparam int CELL_W = $clog2(DIM * DIM);
  localparam int SCORE_W = 16;

  localparam logic [1:0] FUNC_A = 2'd0;
  localparam logic [1:0] FUNC_B = 2'd1;
  localparam logic [1:0] FUNC_ALIGN = 2'd2;

  localparam logic [1:0] ST_PAIR = 2'd0;
  localparam logic [1:0] ST_NONE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_LEFT = 2'd1;
  localparam logic [1:0] DIR_DIAG = 2'd2;
  localparam logic [1:0] DIR_TOP = 2'd3;

  localparam logic [1:0] REG_MATCH = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] symbol;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] a_symbol;
    logic [4:0] a_index;
    logic [4:0] b_index;
    logic [5:0] pair_count;
    logic last;
  } out_beat_t;
endpackage

// ----- src/sla_if.sv -----
// valid/ready channel interfaces for sequence_local_alignment
// depends on sla_pkg
interface sla_in_if import sla_pkg::*; ();
  logic valid;
  logic ready;
  in_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface sla_out_if import sla_pkg::*; ();
  logic valid;
  logic ready;
  out_beat_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- src/sla_cell.sv -----
// cell update of the score grid: max of left, diagonal, top with tie order
// depends on sla_pkg
module sla_cell import sla_pkg::*; (
  input  logic signed [SCORE_W-1:0] left,
  input  logic signed [SCORE_W-1:0] diag,
  input  logic signed [SCORE_W-1:0] top,
  input  logic                      same,
  input  logic signed [7:0]         match_score,
  input  logic signed [7:0]         mismatch_score,
  input  logic signed [7:0]         gap_score,
  output logic signed [SCORE_W-1:0] score,
  output logic [1:0]                dir
);
  logic signed [SCORE_W-1:0] l, d, t;
  always_comb begin
    l = left + SCORE_W'(gap_score);
    t = top + SCORE_W'(gap_score);
    d = diag + (same ? SCORE_W'(match_score) : SCORE_W'(mismatch_score));
    score = l;
    dir = DIR_LEFT;
    if (d >= score) begin
      score = d;
      dir = DIR_DIAG;
    end
    if (t >= score) begin
      score = t;
      dir = DIR_TOP;
    end
  end
endmodule

// ----- src/sequence_local_alignment.sv -----
// top level of sequence_local_alignment: load, grid fill, traceback, output
// depends on sla_pkg, sla_if, sla_cell
// Load beats (func 0 or 1) store a symbol in the A or B memory; symbols
// beyond MAX_LEN are dropped. An align beat fills the score grid one cell
// per cycle in row-major order: the left neighbor comes from a register, the
// top and diagonal from a one-row buffer of scores (column zero is always
// zero and is not stored), so the grid memory holds only directions for
// traceback. The running maximum is kept as cells are written (border zeros
// included, last maximum wins). After the fill, traceback steps through the
// direction memory (registered read: a read state and a wait state per step)
// until it sees the border, collecting pairs in a pair memory. Output emits
// them oldest-first; each result beat goes through pair read, symbol read and
// send, and a beat is only sent once the sink has taken the one before.
// Empty sequences give one status beat at once. No new input beat is taken
// until the last result beat of an align has gone.
module sequence_local_alignment import sla_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  sla_in_if.sink      in_ch,
  sla_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_TRACE = 3'd2;
  localparam logic [2:0] S_TWAIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_ERD = 3'd5;
  localparam logic [2:0] S_ESYM = 3'd6;

  logic [2:0] state;
  logic signed [7:0] match_score, mismatch_score, gap_score;
  logic [CNT_W-1:0] a_count, b_count;

  // sequence memories
  logic [SYM_W-1:0] a_mem [MAX_LEN];
  logic [SYM_W-1:0] b_mem [MAX_LEN];
  logic [SYM_W-1:0] a_rd, b_rd, a_sym_rd;
  logic [IDX_W-1:0] a_addr, b_addr;
  // direction memory
  logic [1:0] dir_mem [DIM*DIM];
  logic [1:0] dir_rd;
  logic [CELL_W-1:0] dir_waddr, dir_raddr;
  logic dir_we;
  logic [1:0] dir_wdata;
  // pair memory
  logic [2*IDX_W-1:0] pair_mem [MAX_LEN];
  logic [2*IDX_W-1:0] pair_rd;

  // fill counters
  logic [DIM_W-1:0] fi, fj;
  // previous row scores for columns 1..MAX_LEN
  logic signed [SCORE_W-1:0] row_buf [MAX_LEN];
  logic signed [SCORE_W-1:0] left_s, diag_s;
  logic signed [SCORE_W-1:0] best_val, cell_s;
  logic [DIM_W-1:0] best_h, best_w;
  logic [1:0] cell_d;
  logic [DIM_W-1:0] h, w;
  logic [CNT_W-1:0] n, k;
  logic out_valid;
  out_beat_t out_q;

  wire accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_q;

  // fill stage: memory reads of a[fi-1], b[fj-1] are issued one cell ahead
  wire border = (fi == '0) || (fj == '0);
  wire [IDX_W-1:0] col_idx = IDX_W'(fj - 1'b1);
  sla_cell u_cell (
    .left(left_s), .diag(diag_s), .top(row_buf[col_idx]), .same(a_rd == b_rd),
    .match_score(match_score), .mismatch_score(mismatch_score),
    .gap_score(gap_score), .score(cell_s), .dir(cell_d)
  );
  wire signed [SCORE_W-1:0] new_s = border ? '0 : cell_s;
  wire last_col = (fj == DIM_W'(b_count));
  wire last_row = (fi == DIM_W'(a_count));
  logic [DIM_W-1:0] ni, nj;
  always_comb begin
    nj = last_col ? '0 : fj + 1'b1;
    ni = last_col ? fi + 1'b1 : fi;
  end
  always_comb begin
    a_addr = IDX_W'(a_count);
    b_addr = IDX_W'(b_count);
    if (state == S_IDLE) begin
      a_addr = '0;
      b_addr = '0;
    end else if (state == S_FILL) begin
      a_addr = IDX_W'(ni - 1'b1);
      b_addr = IDX_W'(nj - 1'b1);
    end else if (state == S_EMIT || state == S_ERD || state == S_ESYM) begin
      a_addr = pair_rd[2*IDX_W-1:IDX_W];
    end
  end

  always_comb begin
    dir_we = (state == S_FILL);
    dir_waddr = CELL_W'(fi * DIM + fj);
    dir_wdata = border ? DIR_NONE : cell_d;
    dir_raddr = CELL_W'(h * DIM + w);
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.data.func == FUNC_A && a_count < CNT_W'(MAX_LEN))
      a_mem[IDX_W'(a_count)] <= in_ch.data.symbol;
    if (accept && in_ch.data.func == FUNC_B && b_count < CNT_W'(MAX_LEN))
      b_mem[IDX_W'(b_count)] <= in_ch.data.symbol;
    a_rd <= a_mem[a_addr];
    b_rd <= b_mem[b_addr];
    a_sym_rd <= a_mem[a_addr];
    if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
    dir_rd <= dir_mem[dir_raddr];
    if (state == S_TWAIT && dir_rd == DIR_DIAG && n < CNT_W'(MAX_LEN))
      pair_mem[IDX_W'(n)] <= {IDX_W'(h - 1'b1), IDX_W'(w - 1'b1)};
    pair_rd <= pair_mem[IDX_W'(n - 1'b1 - k)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      match_score <= 8'sd1;
      mismatch_score <= -8'sd1;
      gap_score <= 8'sd0;
      a_count <= '0;
      b_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MATCH: match_score <= cfg_data;
          REG_MISMATCH: mismatch_score <= cfg_data;
          REG_GAP: gap_score <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.data.func == FUNC_A && a_count < CNT_W'(MAX_LEN))
              a_count <= a_count + 1'b1;
            if (in_ch.data.func == FUNC_B && b_count < CNT_W'(MAX_LEN))
              b_count <= b_count + 1'b1;
            if (in_ch.data.func == FUNC_ALIGN) begin
              if (a_count == '0 || b_count == '0) begin
                out_valid <= 1'b1;
                out_q <= '{ST_EMPTY, 8'd0, 5'd0, 5'd0, 6'd0, 1'b1};
                a_count <= '0;
                b_count <= '0;
              end else begin
                state <= S_FILL;
                fi <= '0;
                fj <= '0;
                best_val <= 16'sh8000;
              end
            end
          end
        end
        S_FILL: begin
          // old value of this column is the diagonal of the next cell
          if (fj != '0) row_buf[col_idx] <= new_s;
          diag_s <= (fj == '0) ? '0 : row_buf[col_idx];
          left_s <= new_s;
          if (new_s >= best_val) begin
            best_val <= new_s;
            best_h <= fi;
            best_w <= fj;
          end
          fi <= ni;
          fj <= nj;
          if (last_col && last_row) begin
            state <= S_TRACE;
            n <= '0;
            if (new_s >= best_val) begin
              h <= fi;
              w <= fj;
            end else begin
              h <= best_h;
              w <= best_w;
            end
          end
        end
        S_TRACE: begin
          // dir read issued this cycle from h,w
          if (h == '0 || w == '0) begin
            k <= '0;
            if (n == '0) begin
              out_valid <= 1'b1;
              out_q <= '{ST_NONE, 8'd0, 5'd0, 5'd0, 6'd0, 1'b1};
              state <= S_IDLE;
              a_count <= '0;
              b_count <= '0;
            end else begin
              state <= S_ERD;
            end
          end else begin
            state <= S_TWAIT;
          end
        end
        S_TWAIT: begin
          case (dir_rd)
            DIR_LEFT: w <= w - 1'b1;
            DIR_TOP: h <= h - 1'b1;
            default: begin
              if (n < CNT_W'(MAX_LEN)) n <= n + 1'b1;
              h <= h - 1'b1;
              w <= w - 1'b1;
            end
          endcase
          state <= S_TRACE;
        end
        S_ERD: begin
          // pair read for index k issued this cycle
          state <= S_ESYM;
        end
        S_ESYM: begin
          // pair_rd valid now; symbol read issued this cycle
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_q <= '{ST_PAIR, a_sym_rd, 5'(pair_rd[2*IDX_W-1:IDX_W]),
                       5'(pair_rd[IDX_W-1:0]), 6'(n), (k == n - 1'b1)};
            if (k == n - 1'b1) begin
              state <= S_IDLE;
              a_count <= '0;
              b_count <= '0;
            end else begin
              k <= k + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/sla_checker.sv -----
// port-level checks for sequence_local_alignment, bound to the top level
// depends on sla_pkg
module sla_checker import sla_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_beat_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_PAIR |-> out_data.last)
    else $error("status beat not last");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_PAIR |-> out_data.pair_count != 6'd0)
    else $error("pair beat with zero count");
endmodule

bind sequence_local_alignment sla_checker u_sla_checker (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// ----- bench/tb_intf.sv -----
// bench copy note: the channel interfaces come from src/sla_if.sv
// this file only holds the shared helper package for the bench
// depends on sla_pkg
package tb_align_pkg;
  import sla_pkg::*;
  localparam int LONG_HOLD = 300;
  localparam logic [1:0] FUNC_NONE = 2'd3;
endpackage

// ----- bench/tb.sv -----
// testbench for sequence_local_alignment: loads sequences, aligns, checks beats
// predicts each alignment with its own score grid and traceback
// depends on sla_pkg, sla_if and tb_align_pkg
module tb;
  import sla_pkg::*;
  import tb_align_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  sla_in_if in_ch();
  sla_out_if out_ch();

  sequence_local_alignment uut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  int match_sc, mismatch_sc, gap_sc;
  logic [7:0] a_syms[MAX_LEN];
  logic [7:0] b_syms[MAX_LEN];
  int a_len, b_len;

  in_beat_t pending_beats[$];
  out_beat_t expected_pairs[$];
  int errors;
  int sent, received;
  bit quiet;
  int hold_cycles;
  bit drain_on;
  bit in_taken;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  function automatic void add_expected(input out_beat_t r);
    expected_pairs = {expected_pairs, r};
  endfunction

  // smith-waterman style grid, no zero floor, ties top > diag > left
  task automatic predict_alignment();
    int score[MAX_LEN+1][MAX_LEN+1];
    logic [1:0] dirs[MAX_LEN+1][MAX_LEN+1];
    int best_v, bh, bw, h, w, n, k, lft, dg, tp, v;
    logic [1:0] d;
    int pa[MAX_LEN], pb[MAX_LEN];
    out_beat_t r;
    if (a_len == 0 || b_len == 0) begin
      r = '0; r.status = ST_EMPTY; r.last = 1;
      add_expected(r);
    end else begin
      best_v = 0; bh = 0; bw = 0;
      for (int i = 0; i <= a_len; i++)
        for (int j = 0; j <= b_len; j++) begin
          if (i == 0 || j == 0) begin
            score[i][j] = 0; dirs[i][j] = DIR_NONE;
          end else begin
            lft = score[i][j-1] + gap_sc;
            tp = score[i-1][j] + gap_sc;
            dg = score[i-1][j-1] +
                 (a_syms[i-1] == b_syms[j-1] ? match_sc : mismatch_sc);
            v = lft; d = DIR_LEFT;
            if (dg >= v) begin v = dg; d = DIR_DIAG; end
            if (tp >= v) begin v = tp; d = DIR_TOP; end
            score[i][j] = v; dirs[i][j] = d;
          end
          // last maximum in row-major order wins
          if (score[i][j] >= best_v) begin best_v = score[i][j]; bh = i; bw = j; end
        end
      h = bh; w = bw; n = 0;
      while (h > 0 && w > 0) begin
        d = dirs[h][w];
        if (d == DIR_LEFT) w--;
        else if (d == DIR_TOP) h--;
        else begin
          pa[n] = h - 1; pb[n] = w - 1; n++;
          h--; w--;
        end
      end
      if (n == 0) begin
        r = '0; r.status = ST_NONE; r.last = 1;
        add_expected(r);
      end else
        for (k = 0; k < n; k++) begin
          r.status = ST_PAIR;
          r.a_symbol = a_syms[pa[n-1-k]];
          r.a_index = 5'(pa[n-1-k]);
          r.b_index = 5'(pb[n-1-k]);
          r.pair_count = 6'(n);
          r.last = (k == n - 1);
          add_expected(r);
        end
    end
    a_len = 0; b_len = 0;
  endtask

  task automatic predict_beat(input in_beat_t b);
    case (b.func)
      FUNC_A: if (a_len < MAX_LEN) begin a_syms[a_len] = b.symbol; a_len++; end
      FUNC_B: if (b_len < MAX_LEN) begin b_syms[b_len] = b.symbol; b_len++; end
      FUNC_ALIGN: predict_alignment();
      default: ;
    endcase
  endtask

  // whether the offered beat went in at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // driver: offers pending beats with random idle bursts
  int send_gap;
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      send_gap = 0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 0;
      end else if (pending_beats.size() > 0) begin
        in_ch.data <= pending_beats.pop_front();
        in_ch.valid <= 1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 12);
      end else
        in_ch.valid <= 0;
    end
  end

  // sink side ready, with bursts of stall and one long hold-off
  int stall_left;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      stall_left = 0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ch.ready <= 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
      if (!quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 12);
    end
  end

  // monitor: predicts on accepted input beats, checks output beats
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_beat(in_ch.data);
        sent++;
      end
      if (out_ch.valid && out_ch.ready) begin
        received++;
        if (expected_pairs.size() == 0)
          report_mismatch($sformatf("unexpected beat %p", out_ch.data));
        else begin
          out_beat_t e;
          e = expected_pairs.pop_front();
          if (out_ch.data.status !== e.status)
            report_mismatch($sformatf("status %0d want %0d", out_ch.data.status, e.status));
          if (out_ch.data.a_symbol !== e.a_symbol)
            report_mismatch($sformatf("a_symbol %0d want %0d", out_ch.data.a_symbol, e.a_symbol));
          if (out_ch.data.a_index !== e.a_index)
            report_mismatch($sformatf("a_index %0d want %0d", out_ch.data.a_index, e.a_index));
          if (out_ch.data.b_index !== e.b_index)
            report_mismatch($sformatf("b_index %0d want %0d", out_ch.data.b_index, e.b_index));
          if (out_ch.data.pair_count !== e.pair_count)
            report_mismatch($sformatf("pair_count %0d want %0d",
                                      out_ch.data.pair_count, e.pair_count));
          if (out_ch.data.last !== e.last)
            report_mismatch($sformatf("last %0d want %0d", out_ch.data.last, e.last));
        end
      end
    end
  end

  function automatic in_beat_t mk(input logic [1:0] f, input logic [7:0] s);
    in_beat_t b;
    b.func = f; b.symbol = s;
    return b;
  endfunction

  function automatic void queue_beat(input in_beat_t b);
    pending_beats = {pending_beats, b};
  endfunction

  // wait for all queued beats to go and all results to come back
  task automatic wait_idle();
    while (pending_beats.size() > 0 || in_ch.valid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= value[7:0];
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_MATCH) match_sc = $signed(value[7:0]);
    else if (idx == REG_MISMATCH) mismatch_sc = $signed(value[7:0]);
    else gap_sc = $signed(value[7:0]);
  endtask

  // a random sequence pair followed by align; small sizes mostly
  task automatic queue_run(input int max_len, input int alpha);
    int la, lb;
    la = $urandom_range(0, max_len);
    lb = $urandom_range(0, max_len);
    if ($urandom_range(0, 9) != 0) begin
      if (la == 0) la = 1;
      if (lb == 0) lb = 1;
    end
    for (int i = 0; i < la; i++) queue_beat(mk(FUNC_A, 8'($urandom_range(0, alpha))));
    for (int i = 0; i < lb; i++) queue_beat(mk(FUNC_B, 8'($urandom_range(0, alpha))));
    // some noise: unused func code
    if ($urandom_range(0, 7) == 0) queue_beat(mk(FUNC_NONE, 8'($urandom)));
    queue_beat(mk(FUNC_ALIGN, 8'($urandom)));
  endtask

  int cfg_sets[5][3] = '{'{1, -1, 0}, '{127, -128, -128}, '{-128, 127, 127},
                         '{2, -1, -1}, '{3, -2, -2}};

  initial begin
    rst = 1;
    cfg_we = 0; cfg_index = REG_MATCH; cfg_data = 0;
    in_ch.valid = 0; in_ch.data = '0;
    out_ch.ready = 0;
    errors = 0; sent = 0; received = 0; quiet = 0; hold_cycles = 0;
    match_sc = 1; mismatch_sc = -1; gap_sc = 0;
    a_len = 0; b_len = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty aligns, extremes, func 3
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    queue_beat(mk(FUNC_A, 8'hff));
    queue_beat(mk(FUNC_ALIGN, 8'hff));
    queue_beat(mk(FUNC_B, 8'h00));
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    queue_beat(mk(FUNC_NONE, 8'haa));
    queue_beat(mk(FUNC_A, 8'h55));
    queue_beat(mk(FUNC_A, 8'haa));
    queue_beat(mk(FUNC_B, 8'haa));
    queue_beat(mk(FUNC_B, 8'h55));
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    queue_beat(mk(FUNC_A, 8'h01));
    queue_beat(mk(FUNC_B, 8'h02));
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    wait_idle();

    // full-length identical sequences plus dropped extra symbols; long hold-off
    for (int i = 0; i < MAX_LEN + 2; i++) queue_beat(mk(FUNC_A, 8'(i * 7)));
    for (int i = 0; i < MAX_LEN + 2; i++) queue_beat(mk(FUNC_B, 8'(i * 7)));
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    for (int i = 0; i < 8; i++) queue_beat(mk(FUNC_A, 8'h11));
    queue_beat(mk(FUNC_B, 8'h11));
    queue_beat(mk(FUNC_ALIGN, 8'h00));
    // hold the sink once results start so the block backs up
    wait (out_ch.valid);
    hold_cycles = LONG_HOLD;
    wait_idle();

    // random phases over several register settings
    for (int s = 0; s < 5; s++) begin
      write_reg(REG_MATCH, cfg_sets[s][0]);
      write_reg(REG_MISMATCH, cfg_sets[s][1]);
      write_reg(REG_GAP, cfg_sets[s][2]);
      if (s == 4) quiet = 1;
      for (int r = 0; r < 5; r++)
        queue_run(($urandom_range(0, 9) == 0) ? MAX_LEN : 6,
                  ($urandom_range(0, 1) == 0) ? 3 : 255);
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
